### design/edma_pkg.sv
// Shared constants for the echo distance moving average block.
package edma_pkg;

	localparam int DATA_W = 16;
	localparam int WINDOW_DEPTH_DEF = 5;
	localparam logic [DATA_W-1:0] TPU_RESET = 16'd117;

endpackage

### design/edma_cell.sv
// One window cell: holds a sample and passes it to the next cell on a shift.
module edma_cell (
	input  logic                        clk,
	input  logic                        shift_en,
	input  logic [edma_pkg::DATA_W-1:0] d_in,
	output logic [edma_pkg::DATA_W-1:0] q
);
	import edma_pkg::*;

	logic [DATA_W-1:0] sample_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			sample_q <= d_in;
		end
	end

	assign q = sample_q;

endmodule

### design/edma_div.sv
// Restoring divider, one quotient bit per cycle.
module edma_div #(
	parameter int DW = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DW-1:0]               dividend,
	input  logic [edma_pkg::DATA_W-1:0] divisor,
	output logic                        busy,
	output logic                        done,
	output logic [DW-1:0]               quotient
);
	import edma_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DW-1:0]     quo_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DATA_W:0]   trial;
	logic              ge;
	logic [DATA_W:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits DATA_W bits
			rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### design/echo_distance_moving_average.sv
// Echo width to distance conversion followed by a moving average over a cell chain.
//
//  port group   dir   payload                          request taken when
//  s_*          in    tdata[15:0] echo_ticks           s_tvalid & s_tready
//  m_*          out   tdata[15:0] mean_distance        m_tvalid & m_tready
//  cfg_*        in    cfg_wdata[15:0] ticks_per_unit   cfg_we
//
// A mean reaches the output register after the conversion and the averaging run, and
// s_tready rises as that mean is presented on m_tdata with m_tvalid: the shared
// restoring divider runs SUM_W steps for the conversion and again for the mean.
// Requests are handled one at a time; a finished mean waits in the output register
// while the next request is already converted. Reset clears control, fill count and
// running sum; the cells are only read once written. No clearing pass.
module echo_distance_moving_average #(
	parameter int WINDOW_DEPTH = edma_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [edma_pkg::DATA_W-1:0] cfg_wdata,   // ticks_per_unit
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [edma_pkg::DATA_W-1:0] s_tdata,     // [15:0] echo_ticks
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [edma_pkg::DATA_W-1:0] m_tdata      // [15:0] mean_distance
);
	import edma_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = DATA_W + $clog2(WINDOW_DEPTH);

	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_AVG, ST_HOLD} state_t;

	state_t            state_q;
	logic [DATA_W-1:0] tpu_q;
	logic [DATA_W-1:0] ticks_q;
	logic [CNT_W-1:0]  fill_q;
	logic [SUM_W-1:0]  sum_q;
	logic              div_start_q;
	logic [SUM_W-1:0]  div_dvd_q;
	logic [DATA_W-1:0] div_dvs_q;
	logic              m_valid_q;
	logic [DATA_W-1:0] m_data_q;

	logic              div_busy;
	logic              div_done;
	logic [SUM_W-1:0]  div_quo;

	logic [DATA_W-1:0] distance;
	logic              shift_en;
	logic              full_now;
	logic [CNT_W-1:0]  count_nxt;
	logic [SUM_W:0]    sum_ext;
	logic [SUM_W-1:0]  sum_nxt;
	logic [DATA_W-1:0] cell_q [WINDOW_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= TPU_RESET;
		end else if (cfg_we) begin
			tpu_q <= cfg_wdata;
		end
	end

	edma_div #(
		.DW(SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dvd_q),
		.divisor  (div_dvs_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// no echo gives zero; a zero divisor saturates
	always_comb begin
		if (ticks_q == '0) begin
			distance = '0;
		end else if (tpu_q == '0) begin
			distance = '1;
		end else begin
			distance = div_quo[DATA_W-1:0];
		end
		shift_en  = (state_q == ST_CONV) && div_done;
		full_now  = fill_q == CNT_W'(WINDOW_DEPTH);
		count_nxt = full_now ? fill_q : fill_q + 1'b1;
		sum_ext   = {1'b0, sum_q} + (SUM_W+1)'(distance)
			- (full_now ? (SUM_W+1)'(cell_q[WINDOW_DEPTH-1]) : '0);
		sum_nxt   = sum_ext[SUM_W-1:0];
	end

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			edma_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.d_in     (distance),
				.q        (cell_q[i])
			);
		end else begin : g_body
			edma_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.d_in     (cell_q[i-1]),
				.q        (cell_q[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			sum_q       <= '0;
			div_start_q <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			// in ST_HOLD the output register is reloaded below instead
			if (m_valid_q && m_tready && state_q != ST_HOLD) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ticks_q     <= s_tdata;
						div_dvd_q   <= SUM_W'(s_tdata);
						div_dvs_q   <= tpu_q;
						div_start_q <= 1'b1;
						state_q     <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (div_done) begin
						sum_q       <= sum_nxt;
						fill_q      <= count_nxt;
						div_dvd_q   <= sum_nxt;
						div_dvs_q   <= DATA_W'(count_nxt);
						div_start_q <= 1'b1;
						state_q     <= ST_AVG;
					end
				end
				ST_AVG: begin
					if (div_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					// quotient holds while the divider is idle
					if (!m_valid_q || m_tready) begin
						m_data_q  <= div_quo[DATA_W-1:0];
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy)
		else $error("divider busy while taking a request");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_DEPTH))
		else $error("fill count beyond window depth");

	a_done_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_CONV || state_q == ST_AVG))
		else $error("divider finished outside a work state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (div_start_q && state_q == ST_CONV))
		else $error("accepted request did not start conversion");

endmodule

### tb/echo_distance_moving_average_tb.sv
// Self-checking testbench for the echo distance moving average block.
module echo_distance_moving_average_tb;

	import edma_pkg::*;

	localparam int WIN = WINDOW_DEPTH_DEF;
	localparam int RANDOM_REQS = 2000;
	localparam int DIR_COUNT = 22;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [DATA_W-1:0]  value;   // echo_ticks or ticks_per_unit
		logic               typed;   // mean given by hand
		logic [DATA_W-1:0]  mean;
	} dir_row_t;

	// hand-typed means follow the window contents at a glance
	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		'{ROW_REQ, 16'd0,     1'b1, 16'd0},
		'{ROW_REQ, 16'd65535, 1'b1, 16'd280},
		'{ROW_REQ, 16'd117,   1'b1, 16'd187},
		'{ROW_REQ, 16'd116,   1'b1, 16'd140},
		'{ROW_REQ, 16'd65535, 1'b1, 16'd224},   // window fills, slot wraps
		'{ROW_REQ, 16'd234,   1'b0, 16'd0},
		'{ROW_REQ, 16'h5555,  1'b0, 16'd0},
		'{ROW_REQ, 16'hAAAA,  1'b0, 16'd0},
		'{ROW_REQ, 16'h00FF,  1'b0, 16'd0},
		'{ROW_REQ, 16'hFF00,  1'b0, 16'd0},
		'{ROW_CFG, 16'd1,     1'b0, 16'd0},
		'{ROW_REQ, 16'd65535, 1'b0, 16'd0},
		'{ROW_REQ, 16'd65535, 1'b0, 16'd0},
		'{ROW_REQ, 16'd65535, 1'b0, 16'd0},
		'{ROW_REQ, 16'd65535, 1'b0, 16'd0},
		'{ROW_REQ, 16'd65535, 1'b1, 16'd65535},
		'{ROW_CFG, 16'd0,     1'b0, 16'd0},      // zero divisor saturates
		'{ROW_REQ, 16'd1,     1'b1, 16'd65535},
		'{ROW_REQ, 16'd0,     1'b1, 16'd52428}, // no echo stays zero
		'{ROW_CFG, 16'd65535, 1'b0, 16'd0},
		'{ROW_REQ, 16'd65535, 1'b0, 16'd0},
		'{ROW_REQ, 16'd65534, 1'b0, 16'd0}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [DATA_W-1:0] cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;   // [15:0] echo_ticks
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;   // [15:0] mean_distance

	// predictor state
	logic [DATA_W-1:0] win_dist [WIN];
	int unsigned       next_slot;
	bit                wrapped;
	logic [DATA_W-1:0] tpu_model;

	logic [DATA_W-1:0] pending_means [$];
	int                mismatches;
	int                means_seen;
	int                reqs_sent;

	echo_distance_moving_average dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [DATA_W-1:0] average_after(input logic [DATA_W-1:0] echo);
		logic [DATA_W-1:0] distance;
		int unsigned       total;
		int unsigned       fill;
		if (echo == '0) begin
			distance = '0;
		end else if (tpu_model == '0) begin
			distance = '1;
		end else begin
			distance = echo / tpu_model;
		end
		win_dist[next_slot] = distance;
		next_slot++;
		if (next_slot == WIN) begin
			next_slot = 0;
			wrapped = 1'b1;
		end
		fill = wrapped ? WIN : next_slot;
		total = 0;
		for (int i = 0; i < fill; i++)
			total += win_dist[i];
		return DATA_W'(total / fill);
	endfunction

	// called at a falling edge; returns at the falling edge after the handshake,
	// tvalid still high
	task automatic send_echo(input logic [DATA_W-1:0] echo, input logic typed,
			input logic [DATA_W-1:0] typed_mean);
		logic [DATA_W-1:0] predicted;
		s_tdata = echo;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = average_after(echo);
		pending_means.push_back(typed ? typed_mean : predicted);
		reqs_sent++;
		@(negedge clk);
	endtask

	task automatic idle_source(input int cycles);
		s_tvalid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// only with the block drained
	task automatic write_tpu(input logic [DATA_W-1:0] value);
		s_tvalid = 1'b0;
		while (pending_means.size() != 0) @(negedge clk);
		@(negedge clk);
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		tpu_model = value;
	endtask

	function automatic int source_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	function automatic logic [DATA_W-1:0] random_tpu();
		case ($urandom_range(0, 9))
			0: return 16'd1;
			1: return 16'd65535;
			2: return 16'd0;
			3, 4, 5, 6: return DATA_W'($urandom_range(1, 400));
			default: return DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] random_echo();
		int unsigned top;
		top = (tpu_model == '0) ? 16 : tpu_model * 6;
		if (top > 65535)
			top = 65535;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return DATA_W'($urandom_range(0, top));
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// stimulus
	initial begin
		int  n;
		bit  burst;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		tpu_model = TPU_RESET;
		next_slot = 0;
		wrapped = 1'b0;
		reqs_sent = 0;
		for (int i = 0; i < WIN; i++)
			win_dist[i] = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_COUNT; i++) begin
			if (DIR_ROWS[i].kind == ROW_CFG) begin
				write_tpu(DIR_ROWS[i].value);
			end else begin
				send_echo(DIR_ROWS[i].value, DIR_ROWS[i].typed, DIR_ROWS[i].mean);
				idle_source(source_gap());
			end
		end

		reqs_sent = 0;
		while (reqs_sent < RANDOM_REQS) begin
			write_tpu(random_tpu());
			burst = ($urandom_range(0, 3) == 0);
			n = $urandom_range(80, 250);
			repeat (n) begin
				send_echo(random_echo(), 1'b0, '0);
				if (!burst) begin
					n = source_gap();
					if (n != 0)
						idle_source(n);
				end
			end
		end

		s_tvalid = 1'b0;
		while (pending_means.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (mismatches == 0) begin
			$display("** echo_distance_moving_average: PASSED **");
		end else begin
			$display("** echo_distance_moving_average: FAILED **");
		end
		$finish;
	end

	// result side: random back-pressure, one long hold-off, checks at the rising edge
	initial begin
		int  stall_left;
		int  r;
		bit  steady;
		bit  held;
		logic [DATA_W-1:0] want;
		m_tready = 1'b0;
		mismatches = 0;
		means_seen = 0;
		stall_left = 0;
		steady = 1'b0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 399) == 0)
				steady = !steady;
			if (!held && means_seen == 150) begin
				held = 1'b1;
				stall_left = 600;
			end
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else if (steady) begin
				m_tready = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				m_tready = (r < 80);
				if (r >= 97)
					stall_left = $urandom_range(10, 60);
				else if (r >= 80)
					stall_left = $urandom_range(0, 2);
			end
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				means_seen++;
				if (pending_means.size() == 0) begin
					$display("%0t: mean_distance expected none, got %0d", $time, m_tdata);
					mismatches++;
				end else begin
					want = pending_means.pop_front();
					if (m_tdata !== want) begin
						$display("%0t: mean_distance expected %0d, got %0d",
							$time, want, m_tdata);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("** echo_distance_moving_average: FAILED **");
		$finish;
	end

endmodule

### filelist.f
design/edma_pkg.sv
design/edma_cell.sv
design/edma_div.sv
design/echo_distance_moving_average.sv
tb/echo_distance_moving_average_tb.sv
